FILE: src/flp_pkg.sv
package flp_pkg;

   // line layout
   localparam int DATE_LEN           = 12;
   localparam int FIELDS_BEFORE_SIZE = 4;

   // size accumulator
   localparam int SIZE_W = 63;
   localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

   // characters with a role in the listing
   localparam logic [7:0] CH_DIR       = 8'h64; // d
   localparam logic [7:0] CH_LINK      = 8'h6C; // l
   localparam logic [7:0] CH_FILE      = 8'h2D; // -
   localparam logic [7:0] CH_BLOCK     = 8'h62; // b
   localparam logic [7:0] CH_CHAR      = 8'h63; // c
   localparam logic [7:0] CH_PIPE      = 8'h70; // p
   localparam logic [7:0] CH_SOCK      = 8'h73; // s
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_SEMI      = 8'h3B;
   localparam logic [7:0] CH_EQUAL     = 8'h3D;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_LANGLE    = 8'h3C;
   localparam logic [7:0] CH_RANGLE    = 8'h3E;
   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_FIELDS,
      PH_DECIDE,
      PH_SIZE,
      PH_PREDATE,
      PH_DATE,
      PH_TAIL,
      PH_DEAD
   } phase_type;

   typedef enum logic [2:0] {
      TM_BETWEEN,
      TM_PLAIN,
      TM_DQUOTE,
      TM_ANGLE,
      TM_COMMENT
   } tmode_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_SHORT,
      ST_BAD_FORMAT,
      ST_DATE_TRUNC
   } status_type;

   typedef enum logic [1:0] {
      KIND_OTHER,
      KIND_FILE,
      KIND_DIR,
      KIND_LINK
   } kind_type;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       line_end;
   } req_word_type;

   typedef struct packed {
      logic [7:0]        date_char;
      logic              date_char_valid;
      logic              line_done;
      logic [1:0]        parse_status;
      logic [1:0]        entry_kind;
      logic [SIZE_W-1:0] entry_size;
   } rsp_word_type;

   // tokenizer state
   typedef struct packed {
      tmode_type  tmode;
      logic       esc;
      logic [2:0] fcount;
   } tok_state_type;

   // tokenizer requests to the phase logic and size unit
   typedef struct packed {
      logic field_done;
      logic size_start;
      logic size_take;
   } tok_ctl_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      return is_ws(c) || (c == CH_COMMA) || (c == CH_SEMI) || (c == CH_EQUAL);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

endpackage

FILE: src/flp_size_unit.sv
module flp_size_unit (
   input  logic [flp_pkg::SIZE_W-1:0] acc,
   input  logic                       open,
   input  logic                       start,
   input  logic                       take,
   input  logic [7:0]                 c,
   output logic [flp_pkg::SIZE_W-1:0] acc_out,
   output logic                       open_out
);

   logic [flp_pkg::SIZE_W-1:0] base_acc;
   logic                       base_open;
   logic [flp_pkg::SIZE_W+3:0] ext;
   logic [flp_pkg::SIZE_W+3:0] prod;
   logic [3:0]                 digit;
   logic                       sat;

   // times ten plus digit, saturating when it spills past the size width; a non-digit closes the size
   always_comb begin
      base_acc  = start ? '0 : acc;
      base_open = start | open;
      digit     = 4'(c - flp_pkg::CH_ZERO);
      ext       = {4'b0, base_acc};
      prod      = (ext << 3) + (ext << 1) + {{(flp_pkg::SIZE_W){1'b0}}, digit};
      sat       = |prod[flp_pkg::SIZE_W+3:flp_pkg::SIZE_W];
      acc_out   = base_acc;
      open_out  = base_open;
      if (take && base_open) begin
         if (flp_pkg::is_digit(c)) begin
            acc_out = sat ? flp_pkg::SIZE_MAX : prod[flp_pkg::SIZE_W-1:0];
         end else begin
            open_out = 1'b0;
         end
      end
   end

endmodule

FILE: src/flp_tokenizer.sv
module flp_tokenizer (
   input  flp_pkg::tok_state_type cur,
   input  logic [7:0]             c,
   output flp_pkg::tok_state_type nxt,
   output flp_pkg::tok_ctl_type   ctl
);

   logic closer_hit;

   always_comb begin
      nxt        = cur;
      ctl        = '0;
      closer_hit = (cur.tmode == flp_pkg::TM_DQUOTE) ? (c == flp_pkg::CH_DQUOTE)
                                                     : (c == flp_pkg::CH_RANGLE);
      case (cur.tmode)
         // unquoted field: runs to a separator
         flp_pkg::TM_PLAIN: begin
            if (flp_pkg::is_sep(c)) begin
               ctl.field_done = 1'b1;
            end else begin
               ctl.size_take = 1'b1;
            end
         end
         // quoted field: escaped bytes are literal
         flp_pkg::TM_DQUOTE, flp_pkg::TM_ANGLE: begin
            if (cur.esc) begin
               nxt.esc       = 1'b0;
               ctl.size_take = 1'b1;
            end else if (closer_hit) begin
               ctl.field_done = 1'b1;
            end else begin
               nxt.esc       = (c == flp_pkg::CH_BACKSLASH);
               ctl.size_take = 1'b1;
            end
         end
         // comment between fields is dropped
         flp_pkg::TM_COMMENT: begin
            if (cur.esc) begin
               nxt.esc = 1'b0;
            end else if (c == flp_pkg::CH_RPAREN) begin
               nxt.tmode = flp_pkg::TM_BETWEEN;
            end else if (c == flp_pkg::CH_BACKSLASH) begin
               nxt.esc = 1'b1;
            end
         end
         // between fields: open a comment or a new field
         default: begin
            if (flp_pkg::is_sep(c)) begin
               nxt = cur;
            end else if (c == flp_pkg::CH_LPAREN) begin
               nxt.tmode = flp_pkg::TM_COMMENT;
               nxt.esc   = 1'b0;
            end else begin
               nxt.fcount     = cur.fcount + 3'd1;
               nxt.esc        = 1'b0;
               ctl.size_start = 1'b1;
               if (c == flp_pkg::CH_DQUOTE) begin
                  nxt.tmode = flp_pkg::TM_DQUOTE;
               end else if (c == flp_pkg::CH_LANGLE) begin
                  nxt.tmode = flp_pkg::TM_ANGLE;
               end else begin
                  nxt.tmode     = flp_pkg::TM_PLAIN;
                  ctl.size_take = 1'b1;
               end
            end
         end
      endcase
      if (ctl.field_done) begin
         nxt.esc   = 1'b0;
         nxt.tmode = flp_pkg::TM_BETWEEN;
      end
   end

endmodule

FILE: src/flp_core.sv
module flp_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  flp_pkg::req_word_type in_word,
   output flp_pkg::rsp_word_type out_word,
   output logic                  has_result
);

   flp_pkg::phase_type         phase_ff, phase_in;
   flp_pkg::tok_state_type     tok_ff, tok_in, tok_nxt;
   flp_pkg::tok_ctl_type       tok_ctl;
   logic [1:0]                 bcount_ff, bcount_in;
   flp_pkg::kind_type          kind_ff, kind_in;
   logic [3:0]                 dcount_ff, dcount_in;
   logic [1:0]                 fail_ff, fail_in;
   logic [flp_pkg::SIZE_W-1:0] size_acc_ff, size_acc_in, size_acc_nxt;
   logic                       size_open_ff, size_open_in, size_open_nxt;

   logic       use_tok;
   logic       size_start;
   logic       size_take;
   logic       emit;
   logic [7:0] c;
   logic       line_end;
   logic       first_ok;

   flp_tokenizer u_tok (
      .cur (tok_ff),
      .c   (c),
      .nxt (tok_nxt),
      .ctl (tok_ctl)
   );

   flp_size_unit u_size (
      .acc      (size_acc_ff),
      .open     (size_open_ff),
      .start    (size_start),
      .take     (size_take),
      .c        (c),
      .acc_out  (size_acc_nxt),
      .open_out (size_open_nxt)
   );

   assign c        = in_word.line_byte;
   assign line_end = in_word.line_end;
   assign first_ok = (c == flp_pkg::CH_BLOCK) || (c == flp_pkg::CH_CHAR)
                  || (c == flp_pkg::CH_DIR)   || (c == flp_pkg::CH_LINK)
                  || (c == flp_pkg::CH_PIPE)  || (c == flp_pkg::CH_SOCK)
                  || (c == flp_pkg::CH_FILE);

   // per byte phase step
   always_comb begin
      phase_in   = phase_ff;
      tok_in     = tok_ff;
      kind_in    = kind_ff;
      dcount_in  = dcount_ff;
      fail_in    = fail_ff;
      bcount_in  = (bcount_ff < 2'd2) ? bcount_ff + 2'd1 : bcount_ff;
      use_tok    = 1'b0;
      size_start = 1'b0;
      size_take  = 1'b0;
      emit       = 1'b0;
      unique case (phase_ff)
         flp_pkg::PH_FIRST: begin
            if (first_ok) begin
               unique case (c)
                  flp_pkg::CH_DIR:  kind_in = flp_pkg::KIND_DIR;
                  flp_pkg::CH_LINK: kind_in = flp_pkg::KIND_LINK;
                  flp_pkg::CH_FILE: kind_in = flp_pkg::KIND_FILE;
                  default:          kind_in = flp_pkg::KIND_OTHER;
               endcase
               phase_in = flp_pkg::PH_FIELDS;
               use_tok  = 1'b1;
            end else begin
               fail_in  = flp_pkg::ST_BAD_FORMAT;
               phase_in = flp_pkg::PH_DEAD;
            end
         end
         flp_pkg::PH_FIELDS: begin
            use_tok = 1'b1;
         end
         flp_pkg::PH_DECIDE: begin
            if (flp_pkg::is_ws(c)) begin
               phase_in = phase_ff;
            end else if (flp_pkg::is_digit(c)) begin
               size_start = 1'b1;
               size_take  = 1'b1;
               phase_in   = flp_pkg::PH_SIZE;
            end else begin
               emit = 1'b1;
            end
         end
         flp_pkg::PH_SIZE: begin
            if (flp_pkg::is_sep(c)) begin
               phase_in = flp_pkg::PH_PREDATE;
            end else begin
               size_take = 1'b1;
            end
         end
         flp_pkg::PH_PREDATE: begin
            emit = !flp_pkg::is_ws(c);
         end
         flp_pkg::PH_DATE: begin
            emit = 1'b1;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      // tokenizer drives fields and the size token
      if (use_tok) begin
         tok_in     = tok_nxt;
         size_start = tok_ctl.size_start;
         size_take  = tok_ctl.size_take;
         if (tok_ctl.field_done
             && (tok_ff.fcount >= 3'(flp_pkg::FIELDS_BEFORE_SIZE))) begin
            phase_in = flp_pkg::PH_DECIDE;
         end
      end

      // date character count
      if (emit) begin
         dcount_in = dcount_ff + 4'd1;
         phase_in  = (dcount_in >= 4'(flp_pkg::DATE_LEN)) ? flp_pkg::PH_TAIL
                                                          : flp_pkg::PH_DATE;
      end
   end

   // result word
   always_comb begin
      out_word                 = '0;
      out_word.date_char       = emit ? c : 8'd0;
      out_word.date_char_valid = emit;
      out_word.line_done       = line_end;
      if (line_end) begin
         if (bcount_in < 2'd2) begin
            out_word.parse_status = flp_pkg::ST_SHORT;
         end else if ((fail_in != flp_pkg::ST_OK) || (phase_in == flp_pkg::PH_DEAD)) begin
            out_word.parse_status = flp_pkg::ST_BAD_FORMAT;
         end else if ((phase_in == flp_pkg::PH_FIELDS)
                      && (tok_in.fcount < 3'(flp_pkg::FIELDS_BEFORE_SIZE))) begin
            out_word.parse_status = flp_pkg::ST_BAD_FORMAT;
         end else begin
            out_word.parse_status = (phase_ff == flp_pkg::PH_TAIL) ? flp_pkg::ST_OK
                                                                   : flp_pkg::ST_DATE_TRUNC;
            out_word.entry_kind   = kind_in;
            out_word.entry_size   = size_acc_nxt;
         end
      end
      has_result = emit | line_end;
   end

   // parser state, cleared at each line end
   always_ff @(posedge clock) begin
      if (reset || (step && line_end)) begin
         phase_ff     <= flp_pkg::PH_FIRST;
         tok_ff       <= '{tmode: flp_pkg::TM_BETWEEN, esc: 1'b0, fcount: 3'd0};
         bcount_ff    <= 2'd0;
         kind_ff      <= flp_pkg::KIND_OTHER;
         dcount_ff    <= 4'd0;
         fail_ff      <= flp_pkg::ST_OK;
         size_acc_ff  <= '0;
         size_open_ff <= 1'b1;
      end else if (step) begin
         phase_ff     <= phase_in;
         tok_ff       <= tok_in;
         bcount_ff    <= bcount_in;
         kind_ff      <= kind_in;
         dcount_ff    <= dcount_in;
         fail_ff      <= fail_in;
         size_acc_ff  <= size_acc_in;
         size_open_ff <= size_open_in;
      end
   end

   assign size_acc_in  = size_acc_nxt;
   assign size_open_in = size_open_nxt;

   // date count never runs past the date length
   a_dcount_range: assert property (@(posedge clock) disable iff (reset)
      dcount_ff <= 4'(flp_pkg::DATE_LEN))
      else $error("date count past date length");

   // first byte phase only at the start of a line
   a_first_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == flp_pkg::PH_FIRST) |-> (bcount_ff == 2'd0 && tok_ff.fcount == 3'd0))
      else $error("first byte phase with line state left over");

   // tail phase only once the whole date has passed
   a_tail_full_date: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == flp_pkg::PH_TAIL) |-> (dcount_ff == 4'(flp_pkg::DATE_LEN)))
      else $error("tail phase with date incomplete");

endmodule

FILE: src/ftp_list_line_parser_unit.sv
// Parses one line of a Unix-style directory listing, one byte per word on the
// req channel, and gives a rsp word for every byte that is a date character or
// ends the line (the final word carries status, entry kind and size). The
// block sustains one byte per clock while rsp is not stalled: an input register
// feeds the byte-step logic, which writes the result register, so a result word
// reaches rsp through both registers after its byte is accepted.
// Bytes that neither carry a date character nor end the line produce no word.
// While a result word waits under a stall on rsp, the input register holds its
// byte and req_stall is raised in the same cycle.
module ftp_list_line_parser_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  flp_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output flp_pkg::rsp_word_type rsp_word
);

   logic                  in_valid_ff, in_valid_in;
   flp_pkg::req_word_type in_word_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   flp_pkg::rsp_word_type rsp_word_ff;
   flp_pkg::rsp_word_type core_word;
   logic                  core_has;
   logic                  advance;
   logic                  fire;
   logic                  accept;

   // handshake between the two register stages
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      rsp_valid_in = advance ? (fire && core_has) : rsp_valid_ff;
   end

   flp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (fire),
      .in_word    (in_word_ff),
      .out_word   (core_word),
      .has_result (core_has)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_word_ff <= req_word;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fire && core_has && advance) begin
         rsp_word_ff <= core_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // every word out carries a date character or a line end
   a_word_has_content: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_word_ff.date_char_valid || rsp_word_ff.line_done))
      else $error("result word with no content");

   // status fields stay zero except on the line end word
   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.line_done) |->
         (rsp_word_ff.parse_status == flp_pkg::ST_OK
          && rsp_word_ff.entry_kind == flp_pkg::KIND_OTHER
          && rsp_word_ff.entry_size == '0))
      else $error("status fields set before line end");

   // a byte held in the input register is consumed once the result side frees
   a_input_drains: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !rsp_valid_ff && !req_valid) |=> !in_valid_ff)
      else $error("input register did not drain");

endmodule

FILE: tb/testbench.sv
module testbench;

   // clock, reset and the two channels
   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   flp_pkg::req_word_type req_word;
   logic                  rsp_valid;
   logic                  rsp_stall;
   flp_pkg::rsp_word_type rsp_word;

   // cycles with no word moving on either channel before the run is abandoned
   localparam int QUIET_LIMIT = 4000;
   // bytes of random lines per idling phase
   localparam int PHASE_BYTES = 460;

   int           idle_pct;
   int           stall_pct;
   int           bytes_sent;
   logic [7:0]   line_buf[$];

   // predicts the result words of the line parser and checks them in order
   class listing_scoreboard;
      flp_pkg::phase_type       phase;
      flp_pkg::tmode_type       tmode;
      bit                       esc;
      bit [2:0]                 nfields;
      bit [1:0]                 nbytes;
      flp_pkg::kind_type        kind;
      bit [flp_pkg::SIZE_W-1:0] size_acc;
      bit                       digits_open;
      bit [3:0]                 ndate;
      bit                       bad;
      flp_pkg::rsp_word_type    expected_words[$];
      int                       fails;

      function new();
         clear_line();
         fails = 0;
      endfunction

      function void clear_line();
         phase       = flp_pkg::PH_FIRST;
         tmode       = flp_pkg::TM_BETWEEN;
         esc         = 0;
         nfields     = 0;
         nbytes      = 0;
         kind        = flp_pkg::KIND_OTHER;
         size_acc    = '0;
         digits_open = 1;
         ndate       = 0;
         bad         = 0;
      endfunction

      function bit blank(logic [7:0] c);
         return (c == flp_pkg::CH_SPACE) || (c >= flp_pkg::CH_TAB && c <= flp_pkg::CH_CR);
      endfunction

      function bit splitter(logic [7:0] c);
         return blank(c) || c == flp_pkg::CH_COMMA || c == flp_pkg::CH_SEMI
                || c == flp_pkg::CH_EQUAL;
      endfunction

      function bit numeral(logic [7:0] c);
         return c >= flp_pkg::CH_ZERO && c <= flp_pkg::CH_NINE;
      endfunction

      function void size_restart();
         size_acc    = '0;
         digits_open = 1;
      endfunction

      // leading decimal digits, saturating at the top of the size range
      function void size_digit(logic [7:0] c);
         logic [63:0] d;
         logic [63:0] lim;
         if (!digits_open) return;
         if (!numeral(c)) begin
            digits_open = 0;
            return;
         end
         d   = {56'd0, c} - {56'd0, flp_pkg::CH_ZERO};
         lim = ({1'b0, flp_pkg::SIZE_MAX} - d) / 64'd10;
         if ({1'b0, size_acc} > lim) size_acc = flp_pkg::SIZE_MAX;
         else size_acc = size_acc * 10 + d[flp_pkg::SIZE_W-1:0];
      endfunction

      function void close_field();
         esc   = 0;
         tmode = flp_pkg::TM_BETWEEN;
         if (nfields >= flp_pkg::FIELDS_BEFORE_SIZE) phase = flp_pkg::PH_DECIDE;
      endfunction

      // inside quotes or a comment; 1 when the closing byte is seen
      function bit quoted_step(logic [7:0] c, logic [7:0] closer);
         if (esc) begin
            esc = 0;
            return 0;
         end
         if (c == closer) return 1;
         if (c == flp_pkg::CH_BACKSLASH) esc = 1;
         return 0;
      endfunction

      function void token_step(logic [7:0] c);
         logic [7:0] closer;
         closer = (tmode == flp_pkg::TM_DQUOTE) ? flp_pkg::CH_DQUOTE : flp_pkg::CH_RANGLE;
         case (tmode)
            flp_pkg::TM_PLAIN: begin
               if (splitter(c)) close_field();
               else size_digit(c);
            end
            flp_pkg::TM_DQUOTE, flp_pkg::TM_ANGLE: begin
               if (quoted_step(c, closer)) close_field();
               else size_digit(c);
            end
            flp_pkg::TM_COMMENT: begin
               if (quoted_step(c, flp_pkg::CH_RPAREN)) tmode = flp_pkg::TM_BETWEEN;
            end
            default: begin
               if (!splitter(c)) begin
                  if (c == flp_pkg::CH_LPAREN) begin
                     tmode = flp_pkg::TM_COMMENT;
                     esc   = 0;
                  end else begin
                     nfields++;
                     size_restart();
                     esc = 0;
                     if (c == flp_pkg::CH_DQUOTE) tmode = flp_pkg::TM_DQUOTE;
                     else if (c == flp_pkg::CH_LANGLE) tmode = flp_pkg::TM_ANGLE;
                     else begin
                        tmode = flp_pkg::TM_PLAIN;
                        size_digit(c);
                     end
                  end
               end
            end
         endcase
      endfunction

      function bit date_step();
         ndate++;
         phase = (ndate >= flp_pkg::DATE_LEN) ? flp_pkg::PH_TAIL : flp_pkg::PH_DATE;
         return 1;
      endfunction

      // accepted request word: advance the line state, queue any result word
      function void note_byte(flp_pkg::req_word_type w);
         logic [7:0]            c;
         bit                    fin;
         bit                    was_tail;
         bit                    emit;
         flp_pkg::rsp_word_type r;
         c        = w.line_byte;
         fin      = w.line_end;
         was_tail = (phase == flp_pkg::PH_TAIL);
         emit     = 0;
         if (nbytes < 2) nbytes++;
         case (phase)
            flp_pkg::PH_FIRST: begin
               if (c == flp_pkg::CH_BLOCK || c == flp_pkg::CH_CHAR ||
                   c == flp_pkg::CH_DIR || c == flp_pkg::CH_LINK ||
                   c == flp_pkg::CH_PIPE || c == flp_pkg::CH_SOCK ||
                   c == flp_pkg::CH_FILE) begin
                  kind = (c == flp_pkg::CH_DIR) ? flp_pkg::KIND_DIR :
                         (c == flp_pkg::CH_LINK) ? flp_pkg::KIND_LINK :
                         (c == flp_pkg::CH_FILE) ? flp_pkg::KIND_FILE : flp_pkg::KIND_OTHER;
                  phase = flp_pkg::PH_FIELDS;
                  token_step(c);
               end else begin
                  bad   = 1;
                  phase = flp_pkg::PH_DEAD;
               end
            end
            flp_pkg::PH_FIELDS: token_step(c);
            flp_pkg::PH_DECIDE: begin
               if (!blank(c)) begin
                  if (numeral(c)) begin
                     size_restart();
                     size_digit(c);
                     phase = flp_pkg::PH_SIZE;
                  end else emit = date_step();
               end
            end
            flp_pkg::PH_SIZE: begin
               if (splitter(c)) phase = flp_pkg::PH_PREDATE;
               else size_digit(c);
            end
            flp_pkg::PH_PREDATE: begin
               if (!blank(c)) emit = date_step();
            end
            flp_pkg::PH_DATE: emit = date_step();
            default: ;
         endcase
         if (!emit && !fin) return;
         r = '0;
         if (emit) begin
            r.date_char       = c;
            r.date_char_valid = 1;
         end
         if (fin) begin
            r.line_done = 1;
            if (nbytes < 2) r.parse_status = flp_pkg::ST_SHORT;
            else if (bad || phase == flp_pkg::PH_DEAD) r.parse_status = flp_pkg::ST_BAD_FORMAT;
            else if (phase == flp_pkg::PH_FIELDS && nfields < flp_pkg::FIELDS_BEFORE_SIZE)
               r.parse_status = flp_pkg::ST_BAD_FORMAT;
            else begin
               r.parse_status = was_tail ? flp_pkg::ST_OK : flp_pkg::ST_DATE_TRUNC;
               r.entry_kind   = kind;
               r.entry_size   = size_acc;
            end
            clear_line();
         end
         expected_words.push_back(r);
      endfunction

      function void match_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            fails++;
            if (fails <= 200) $error("%s: expected %0h, got %0h", name, want, got);
         end
      endfunction

      // accepted result word against the oldest prediction
      function void check_word(flp_pkg::rsp_word_type got);
         flp_pkg::rsp_word_type want;
         if (expected_words.size() == 0) begin
            fails++;
            if (fails <= 200)
               $error("unexpected result word: date_char %0h, line_done %0b",
                      got.date_char, got.line_done);
            return;
         end
         want = expected_words.pop_front();
         match_field("date_char", want.date_char, got.date_char);
         match_field("date_char_valid", want.date_char_valid, got.date_char_valid);
         match_field("line_done", want.line_done, got.line_done);
         match_field("parse_status", want.parse_status, got.parse_status);
         match_field("entry_kind", want.entry_kind, got.entry_kind);
         match_field("entry_size", want.entry_size, got.entry_size);
      endfunction
   endclass

   listing_scoreboard sb;

   ftp_list_line_parser_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // clock
   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // line generation helpers
   function automatic logic [7:0] rand_any();
      return 8'($urandom_range(0, 255));
   endfunction

   // a byte that neither separates nor opens a quote or comment
   function automatic logic [7:0] rand_plain();
      logic [7:0] c;
      do begin
         if ($urandom_range(9) == 0) c = rand_any();
         else c = 8'($urandom_range(33, 126));
      end while (c == flp_pkg::CH_COMMA || c == flp_pkg::CH_SEMI ||
                 c == flp_pkg::CH_EQUAL || c == flp_pkg::CH_DQUOTE ||
                 c == flp_pkg::CH_LANGLE || c == flp_pkg::CH_LPAREN ||
                 c == flp_pkg::CH_SPACE ||
                 (c >= flp_pkg::CH_TAB && c <= flp_pkg::CH_CR));
      return c;
   endfunction

   function automatic logic [7:0] rand_blank();
      if ($urandom_range(3) != 0) return flp_pkg::CH_SPACE;
      return 8'($urandom_range(flp_pkg::CH_TAB, flp_pkg::CH_CR));
   endfunction

   function automatic logic [7:0] rand_sep();
      case ($urandom_range(5))
         0: return flp_pkg::CH_COMMA;
         1: return flp_pkg::CH_SEMI;
         2: return flp_pkg::CH_EQUAL;
         default: return rand_blank();
      endcase
   endfunction

   function automatic void add_digits(int n);
      repeat (n) line_buf.push_back(8'($urandom_range(flp_pkg::CH_ZERO, flp_pkg::CH_NINE)));
   endfunction

   function automatic void add_word();
      repeat ($urandom_range(1, 8)) line_buf.push_back(rand_plain());
   endfunction

   // quoted field or comment body with escapes, rarely left open
   function automatic void add_quoted(logic [7:0] opener, logic [7:0] closer);
      line_buf.push_back(opener);
      repeat ($urandom_range(0, 6)) begin
         case ($urandom_range(5))
            0: begin
               line_buf.push_back(flp_pkg::CH_BACKSLASH);
               line_buf.push_back(($urandom_range(1) != 0) ? closer : rand_any());
            end
            1: line_buf.push_back(flp_pkg::CH_SPACE);
            2: add_digits(1);
            default: line_buf.push_back(rand_plain());
         endcase
      end
      if ($urandom_range(19) != 0) line_buf.push_back(closer);
   endfunction

   function automatic void add_gap();
      repeat ($urandom_range(1, 3)) line_buf.push_back(rand_sep());
      if ($urandom_range(5) == 0) begin
         add_quoted(flp_pkg::CH_LPAREN, flp_pkg::CH_RPAREN);
         line_buf.push_back(rand_sep());
      end
   endfunction

   // size digits, now and then long enough to saturate
   function automatic void add_size();
      case ($urandom_range(9))
         0: begin
            add_digits(0);
            line_buf.push_back(8'h39); line_buf.push_back(8'h32);
            line_buf.push_back(8'h32); line_buf.push_back(8'h33);
            line_buf.push_back(8'h33); line_buf.push_back(8'h37);
            line_buf.push_back(8'h32); line_buf.push_back(8'h30);
            line_buf.push_back(8'h33); line_buf.push_back(8'h36);
            line_buf.push_back(8'h38); line_buf.push_back(8'h35);
            line_buf.push_back(8'h34); line_buf.push_back(8'h37);
            line_buf.push_back(8'h37); line_buf.push_back(8'h35);
            line_buf.push_back(8'h38); line_buf.push_back(8'h30);
            line_buf.push_back(8'($urandom_range(8'h36, 8'h39)));
         end
         1, 2: add_digits($urandom_range(19, 22));
         default: add_digits($urandom_range(1, 10));
      endcase
      if ($urandom_range(3) == 0) add_word();
   endfunction

   // well-formed listing line with random content
   function automatic void build_listing();
      logic [7:0] kinds[7];
      kinds = '{flp_pkg::CH_BLOCK, flp_pkg::CH_CHAR, flp_pkg::CH_DIR, flp_pkg::CH_LINK,
                flp_pkg::CH_PIPE, flp_pkg::CH_SOCK, flp_pkg::CH_FILE};
      line_buf.delete();
      line_buf.push_back(kinds[$urandom_range(0, 6)]);
      repeat ($urandom_range(0, 9)) line_buf.push_back(rand_plain());
      for (int f = 1; f < flp_pkg::FIELDS_BEFORE_SIZE; f++) begin
         add_gap();
         case ($urandom_range(5))
            0: add_quoted(flp_pkg::CH_DQUOTE, flp_pkg::CH_DQUOTE);
            1: add_quoted(flp_pkg::CH_LANGLE, flp_pkg::CH_RANGLE);
            2: add_digits($urandom_range(1, 4));
            default: add_word();
         endcase
      end
      if ($urandom_range(9) < 7) begin
         repeat ($urandom_range(1, 3)) line_buf.push_back(rand_blank());
         add_size();
         line_buf.push_back(rand_sep());
      end
      repeat ($urandom_range(0, 2)) line_buf.push_back(rand_blank());
      repeat (($urandom_range(5) != 0) ? flp_pkg::DATE_LEN
                                       : $urandom_range(0, flp_pkg::DATE_LEN - 1)) begin
         if ($urandom_range(9) < 7) line_buf.push_back(8'($urandom_range(32, 126)));
         else line_buf.push_back(rand_any());
      end
      repeat ($urandom_range(0, 8)) line_buf.push_back(rand_plain());
   endfunction

   function automatic void build_noise();
      line_buf.delete();
      repeat ($urandom_range(1, 30)) line_buf.push_back(rand_any());
      if ($urandom_range(1) != 0) line_buf[0] = flp_pkg::CH_FILE;
   endfunction

   // one request word, with random idle cycles ahead of it
   task automatic push_byte(input logic [7:0] b, input logic fin);
      flp_pkg::req_word_type w;
      w.line_byte = b;
      w.line_end  = fin;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(w);
   endtask

   task automatic send_line();
      for (int i = 0; i < line_buf.size(); i++)
         push_byte(line_buf[i], i == line_buf.size() - 1);
      bytes_sent += line_buf.size();
   endtask

   task automatic send_fixed(input logic [7:0] bytes[$]);
      line_buf = bytes;
      send_line();
   endtask

   // result side: check accepted words, stall at random
   initial begin
      rsp_stall <= 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && !rsp_stall) sb.check_word(rsp_word);
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog on cycles with no word accepted
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0)) quiet = 0;
         else quiet++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // reset, directed lines, random phases, drain
   initial begin
      int pcts[4][2];
      sb         = new();
      idle_pct   = 0;
      stall_pct  = 0;
      bytes_sent = 0;
      pcts       = '{'{0, 0}, '{81, 0}, '{0, 81}, '{7, 7}};
      reset     <= 1;
      req_valid <= 0;
      req_word  <= '0;
      repeat (6) @(posedge clock);
      reset <= 0;

      // single-byte line
      send_fixed('{flp_pkg::CH_FILE});
      // bad first byte, high and nul bytes
      send_fixed('{8'hFF, 8'h00});
      // too few fields
      send_fixed('{flp_pkg::CH_DIR, flp_pkg::CH_SPACE, 8'h78});
      // open double quote runs to the line end with four fields begun
      send_fixed('{flp_pkg::CH_PIPE, flp_pkg::CH_SPACE, 8'h61, flp_pkg::CH_COMMA, 8'h62,
                   flp_pkg::CH_TAB, flp_pkg::CH_DQUOTE, 8'h31, flp_pkg::CH_BACKSLASH,
                   flp_pkg::CH_DQUOTE});
      // symbolic link, too few fields after the kind byte
      send_fixed('{flp_pkg::CH_LINK, flp_pkg::CH_CR});

      foreach (pcts[p]) begin
         idle_pct   = pcts[p][0];
         stall_pct  = pcts[p][1];
         bytes_sent = 0;
         while (bytes_sent < PHASE_BYTES) begin
            case ($urandom_range(19))
               14, 15, 16: begin
                  build_listing();
                  while (line_buf.size() > 1 && $urandom_range(3) != 0)
                     void'(line_buf.pop_back());
               end
               17, 18, 19: build_noise();
               default: build_listing();
            endcase
            send_line();
         end
      end
      req_valid <= 0;
      stall_pct = 0;

      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.fails == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
